// ----- src/cnfp_pkg.sv -----
package cnfp_pkg;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_TOP     = 3'd0,
    MODE_CLAUSE  = 3'd1,
    MODE_SIGN    = 3'd2,
    MODE_DIGITS  = 3'd3,
    MODE_COMMENT = 3'd4,
    MODE_ERROR   = 3'd5,
    MODE_DONE    = 3'd6
  } mode_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  localparam int VAR_OUT_W = 24;

  // Characters
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_P       = 8'h70;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Queue depth between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // Results caused by one byte (one or two)
  typedef struct packed {
    logic                 two;
    kind_t                kind0;
    logic [VAR_OUT_W-1:0] var0;
    logic                 neg0;
    kind_t                kind1;
  } res_pair_t;

endpackage

// ----- src/cnf_clause_text_parser.sv -----
// A word passes from the front through the queue into the output register before it leaves.
// Throughput: one byte per cycle while the queue is not full; a byte causing two words holds
//   the output for both words, set by the single output register draining the front/back queue (4 entries).
// Reset: synchronous, active-low rst_n; parser returns to top level awaiting a clause,
//   queue and output register empty. No clearing pass.
module cnf_clause_text_parser #(
  parameter int VAR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] end_of_input
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [23:0] variable, [24] negated, [31:25] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last word caused by one input byte
);

  // Front: classifies each byte, runs the mode machine and the x10 accumulate,
  // and pushes one entry (one or two result words) per byte that yields output.
  // Back: serializes entries into words behind an output register.

  logic                           q_full, q_push, q_pop, q_not_empty;
  cnfp_pkg::res_pair_t            q_wdata, q_rdata;
  cnfp_pkg::kind_t                o_kind;
  logic [cnfp_pkg::VAR_OUT_W-1:0] o_var;
  logic                           o_neg;

  cnfp_front #(.VAR_BITS(VAR_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .data_byte    (in_tdata),
    .end_of_input (in_tuser),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  cnfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rdata)
  );

  cnfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (o_kind),
    .out_var     (o_var),
    .out_neg     (o_neg),
    .out_last    (out_tlast)
  );

  assign out_tuser = o_kind;
  assign out_tdata = {7'b0, o_neg, o_var};

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue overflow");

  // done and error always close the run of a byte
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (o_kind == cnfp_pkg::KIND_DONE || o_kind == cnfp_pkg::KIND_ERR))
      |-> out_tlast)
    else $error("terminal word not last");

  // only literals carry payload
  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && o_kind != cnfp_pkg::KIND_LIT) |-> (o_var == '0 && !o_neg))
    else $error("payload on non-literal");

  // a pending second word follows a non-last word
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("pair broken");

endmodule

// ----- src/cnfp_front.sv -----
module cnfp_front #(
  parameter int VAR_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_input,
  input  logic                 q_full,
  output logic                 q_push,
  output cnfp_pkg::res_pair_t  q_data
);

  localparam int SW = VAR_BITS + 4;

  cnfp_pkg::mode_t     mode_r, mode_nxt;
  logic [VAR_BITS-1:0] val_r, val_nxt;
  logic                neg_r, neg_nxt;

  logic                is_space, is_digit, accept;
  logic [3:0]          digit;
  logic [SW-1:0]       acc;
  cnfp_pkg::mode_t     mode_mid;
  logic                fin, sec, do_start, do_fail;
  cnfp_pkg::kind_t     fin_kind, sec_kind;
  logic                fin_neg;
  logic [VAR_BITS-1:0] fin_var;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_space = (data_byte >= cnfp_pkg::CH_TAB && data_byte <= cnfp_pkg::CH_CR) ||
                    data_byte == cnfp_pkg::CH_SPACE;
  assign is_digit = data_byte >= cnfp_pkg::CH_ZERO && data_byte <= cnfp_pkg::CH_NINE;
  assign digit    = data_byte[3:0];
  // value*10 + digit as value*8 + value*2 + digit
  assign acc      = {1'b0, val_r, 3'b000} + {3'b000, val_r, 1'b0} + SW'(digit);

  always_comb begin
    mode_mid = mode_r;
    fin      = 1'b0;
    fin_kind = cnfp_pkg::KIND_END;
    fin_var  = '0;
    fin_neg  = 1'b0;
    val_nxt  = val_r;
    neg_nxt  = neg_r;
    sec      = 1'b0;
    sec_kind = cnfp_pkg::KIND_ERR;
    do_start = 1'b0;
    do_fail  = 1'b0;

    // a non-digit or the end closes the number in progress
    if (mode_r == cnfp_pkg::MODE_DIGITS && (end_of_input || !is_digit)) begin
      fin = 1'b1;
      if (val_r == '0) begin
        fin_kind = cnfp_pkg::KIND_END;
        mode_mid = cnfp_pkg::MODE_TOP;
      end else begin
        fin_kind = cnfp_pkg::KIND_LIT;
        fin_var  = val_r;
        fin_neg  = neg_r;
        mode_mid = cnfp_pkg::MODE_CLAUSE;
      end
      val_nxt = '0;
      neg_nxt = 1'b0;
    end

    mode_nxt = mode_mid;
    case (mode_mid)
      cnfp_pkg::MODE_TOP: begin
        if (end_of_input) begin
          mode_nxt = cnfp_pkg::MODE_DONE;
          sec      = 1'b1;
          sec_kind = cnfp_pkg::KIND_DONE;
        end else if (is_space) begin
          mode_nxt = mode_mid;
        end else if (data_byte == cnfp_pkg::CH_C || data_byte == cnfp_pkg::CH_P) begin
          mode_nxt = cnfp_pkg::MODE_COMMENT;
        end else begin
          do_start = 1'b1;
        end
      end
      cnfp_pkg::MODE_CLAUSE: begin
        if (end_of_input) do_fail = 1'b1;
        else if (!is_space) do_start = 1'b1;
      end
      cnfp_pkg::MODE_SIGN: begin
        if (!end_of_input && is_digit) begin
          val_nxt  = VAR_BITS'(digit);
          mode_nxt = cnfp_pkg::MODE_DIGITS;
        end else begin
          do_fail = 1'b1;
        end
      end
      cnfp_pkg::MODE_DIGITS: begin
        val_nxt = acc[VAR_BITS-1:0];
        if (|acc[SW-1:VAR_BITS]) do_fail = 1'b1;
      end
      cnfp_pkg::MODE_COMMENT: begin
        if (end_of_input) begin
          mode_nxt = cnfp_pkg::MODE_DONE;
          sec      = 1'b1;
          sec_kind = cnfp_pkg::KIND_DONE;
        end else if (data_byte == cnfp_pkg::CH_NEWLINE) begin
          mode_nxt = cnfp_pkg::MODE_TOP;
        end
      end
      default: mode_nxt = mode_mid;
    endcase

    if (do_start) begin
      if (data_byte == cnfp_pkg::CH_MINUS) begin
        neg_nxt  = 1'b1;
        val_nxt  = '0;
        mode_nxt = cnfp_pkg::MODE_SIGN;
      end else if (data_byte == cnfp_pkg::CH_PLUS) begin
        neg_nxt  = 1'b0;
        val_nxt  = '0;
        mode_nxt = cnfp_pkg::MODE_SIGN;
      end else if (is_digit) begin
        neg_nxt  = 1'b0;
        val_nxt  = VAR_BITS'(digit);
        mode_nxt = cnfp_pkg::MODE_DIGITS;
      end else begin
        do_fail = 1'b1;
      end
    end

    if (do_fail) begin
      mode_nxt = cnfp_pkg::MODE_ERROR;
      sec      = 1'b1;
      sec_kind = cnfp_pkg::KIND_ERR;
    end
  end

  assign q_push       = accept && (fin || sec);
  assign q_data.two   = fin && sec;
  assign q_data.kind0 = fin ? fin_kind : sec_kind;
  assign q_data.var0  = cnfp_pkg::VAR_OUT_W'(fin_var);
  assign q_data.neg0  = fin_neg;
  assign q_data.kind1 = sec_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cnfp_pkg::MODE_TOP;
      val_r  <= '0;
      neg_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      val_r  <= val_nxt;
      neg_r  <= neg_nxt;
    end
  end

endmodule

// ----- src/cnfp_queue.sv -----
module cnfp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cnfp_pkg::res_pair_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output cnfp_pkg::res_pair_t pop_data
);

  cnfp_pkg::res_pair_t            mem_r [cnfp_pkg::QDEPTH];
  logic [cnfp_pkg::QPTR_W-1:0]    wr_r, rd_r;
  logic [cnfp_pkg::QPTR_W:0]      cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full      = cnt_r == (cnfp_pkg::QPTR_W + 1)'(cnfp_pkg::QDEPTH);
  assign not_empty = cnt_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/cnfp_back.sv -----
module cnfp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_not_empty,
  input  cnfp_pkg::res_pair_t           q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cnfp_pkg::kind_t               out_kind,
  output logic [cnfp_pkg::VAR_OUT_W-1:0] out_var,
  output logic                          out_neg,
  output logic                          out_last
);

  logic                           valid_r, valid_nxt;
  logic                           pend_r, pend_nxt;
  cnfp_pkg::kind_t                pend_kind_r, pend_kind_nxt;
  cnfp_pkg::kind_t                kind_r, kind_nxt;
  logic [cnfp_pkg::VAR_OUT_W-1:0] var_r, var_nxt;
  logic                           neg_r, neg_nxt;
  logic                           last_r, last_nxt;
  logic                           load;

  assign load = !valid_r || out_ready;

  always_comb begin
    valid_nxt     = valid_r;
    pend_nxt      = pend_r;
    pend_kind_nxt = pend_kind_r;
    kind_nxt      = kind_r;
    var_nxt       = var_r;
    neg_nxt       = neg_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;
    if (load) begin
      if (pend_r) begin
        // second word of a pair: done or error, no payload
        valid_nxt = 1'b1;
        kind_nxt  = pend_kind_r;
        var_nxt   = '0;
        neg_nxt   = 1'b0;
        last_nxt  = 1'b1;
        pend_nxt  = 1'b0;
      end else if (q_not_empty) begin
        q_pop         = 1'b1;
        valid_nxt     = 1'b1;
        kind_nxt      = q_data.kind0;
        var_nxt       = q_data.var0;
        neg_nxt       = q_data.neg0;
        last_nxt      = !q_data.two;
        pend_nxt      = q_data.two;
        pend_kind_nxt = q_data.kind1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_kind_r <= pend_kind_nxt;
    kind_r      <= kind_nxt;
    var_r       <= var_nxt;
    neg_r       <= neg_nxt;
    last_r      <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_var   = var_r;
  assign out_neg   = neg_r;
  assign out_last  = last_r;

endmodule

// ----- tb/cnf_clause_text_parser_tb.sv -----
`timescale 1ns / 100ps

module cnf_clause_text_parser_tb;

  localparam int VAR_BITS = 24;
  localparam longint unsigned VAR_MAX = (64'd1 << VAR_BITS) - 64'd1;
  localparam int RANDOM_BYTES = 1525;   // directed rows included
  localparam int PAUSE_AT = 800;        // sender waits for an empty scoreboard here
  localparam int CALM_FROM = 300;       // no idling on either side in this window
  localparam int CALM_TO = 650;

  // one result word as the parser should emit it
  typedef struct {
    cnfp_pkg::kind_t kind;
    logic [23:0]     variable;
    logic            negated;
    logic            last;
  } parse_word_t;

  // directed stimulus row; typed rows carry their single expected word
  typedef struct {
    logic [7:0]      data;
    logic            eoi;
    bit              typed;
    cnfp_pkg::kind_t kind;
    logic [23:0]     variable;
    logic            neg;
  } dir_row_t;

  typedef enum int {SGN_NONE, SGN_MINUS, SGN_PLUS} sign_t;

  // how the stream is closed; only one of these fits in a run
  typedef enum int {
    END_AT_TOP, END_IN_COMMENT, END_AFTER_ZERO, END_IN_DIGITS, END_IN_CLAUSE,
    BAD_IN_CLAUSE, BAD_AFTER_DIGITS, SIGN_THEN_SPACE, SIGN_THEN_END, SIGN_THEN_BAD,
    VAR_TOO_BIG
  } ending_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int in_idle_pct = 34;
  int out_idle_pct = 34;
  int n_sent = 0;
  int mismatches = 0;

  parse_word_t pending_words[$];   // words still owed by the block, oldest first
  parse_word_t step_words[$];      // words caused by the byte being predicted

  // predictor state
  cnfp_pkg::mode_t pmode = cnfp_pkg::MODE_TOP;
  longint unsigned pval = 0;
  logic            pneg = 1'b0;

  // directed part: comment with extreme bytes, every whitespace byte but form feed, signed literals,
  // literals ended by a sign instead of a space, clause end straight into a comment
  dir_row_t dir_tab [25] = '{
    '{cnfp_pkg::CH_C,          1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},  // comment ...
    '{8'hFF,                   1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{8'h00,                   1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_NEWLINE,    1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},  // ... ends
    '{cnfp_pkg::CH_TAB,        1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_CR,         1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_SPACE,      1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_MINUS,      1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_ZERO + 8'd1, 1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_SPACE,      1'b0, 1'b1, cnfp_pkg::KIND_LIT, 24'd1, 1'b1},  // -1
    '{cnfp_pkg::CH_PLUS,       1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_ZERO + 8'd5, 1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_MINUS,      1'b0, 1'b1, cnfp_pkg::KIND_LIT, 24'd5, 1'b0},  // +5, sign
    '{cnfp_pkg::CH_ZERO + 8'd2, 1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_ZERO,       1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{8'd11,                   1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},  // -20
    '{cnfp_pkg::CH_ZERO,       1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_NEWLINE,    1'b0, 1'b1, cnfp_pkg::KIND_END, 24'd0, 1'b0},  // clause end
    '{cnfp_pkg::CH_P,          1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},  // empty p line
    '{cnfp_pkg::CH_NEWLINE,    1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_PLUS,       1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},  // 3, predicted
    '{cnfp_pkg::CH_ZERO,       1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0},
    '{cnfp_pkg::CH_C,          1'b0, 1'b1, cnfp_pkg::KIND_END, 24'd0, 1'b0},  // +0, comment
    '{cnfp_pkg::CH_NEWLINE,    1'b0, 1'b0, cnfp_pkg::KIND_LIT, 24'd0, 1'b0}
  };

  cnf_clause_text_parser #(
    .VAR_BITS(VAR_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #3ms;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_ws(logic [7:0] c);
    return (c >= cnfp_pkg::CH_TAB && c <= cnfp_pkg::CH_CR) || c == cnfp_pkg::CH_SPACE;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= cnfp_pkg::CH_ZERO && c <= cnfp_pkg::CH_NINE;
  endfunction

  function automatic void emit(cnfp_pkg::kind_t k, logic [23:0] v, logic n);
    parse_word_t w;
    w.kind = k;
    w.variable = v;
    w.negated = n;
    w.last = 1'b0;
    step_words.insert(step_words.size(), w);
  endfunction

  function automatic void parse_error();
    pmode = cnfp_pkg::MODE_ERROR;
    emit(cnfp_pkg::KIND_ERR, 24'd0, 1'b0);
  endfunction

  // first byte of a number: sign, digit, or anything else is an error
  function automatic void number_begin(logic [7:0] c);
    if (c == cnfp_pkg::CH_MINUS || c == cnfp_pkg::CH_PLUS) begin
      pneg = (c == cnfp_pkg::CH_MINUS);
      pval = 0;
      pmode = cnfp_pkg::MODE_SIGN;
    end else if (is_dig(c)) begin
      pneg = 1'b0;
      pval = c - cnfp_pkg::CH_ZERO;
      pmode = cnfp_pkg::MODE_DIGITS;
    end else begin
      parse_error();
    end
  endfunction

  // fills step_words with what one accepted byte causes
  function automatic void parse_byte(logic [7:0] c, logic eoi);
    step_words.delete();
    // a number ends at the first non-digit, which is then parsed on its own
    if (pmode == cnfp_pkg::MODE_DIGITS && (eoi || !is_dig(c))) begin
      if (pval == 0) begin
        emit(cnfp_pkg::KIND_END, 24'd0, 1'b0);
        pmode = cnfp_pkg::MODE_TOP;
      end else begin
        emit(cnfp_pkg::KIND_LIT, pval[23:0], pneg);
        pmode = cnfp_pkg::MODE_CLAUSE;
      end
      pval = 0;
      pneg = 1'b0;
    end
    case (pmode)
      cnfp_pkg::MODE_TOP: begin
        if (eoi) begin
          pmode = cnfp_pkg::MODE_DONE;
          emit(cnfp_pkg::KIND_DONE, 24'd0, 1'b0);
        end else if (is_ws(c)) begin
        end else if (c == cnfp_pkg::CH_C || c == cnfp_pkg::CH_P) begin
          pmode = cnfp_pkg::MODE_COMMENT;
        end else begin
          number_begin(c);
        end
      end
      cnfp_pkg::MODE_CLAUSE: begin
        if (eoi) parse_error();
        else if (!is_ws(c)) number_begin(c);
      end
      cnfp_pkg::MODE_SIGN: begin
        if (!eoi && is_dig(c)) begin
          pval = c - cnfp_pkg::CH_ZERO;
          pmode = cnfp_pkg::MODE_DIGITS;
        end else begin
          parse_error();
        end
      end
      cnfp_pkg::MODE_DIGITS: begin
        pval = pval * 10 + (c - cnfp_pkg::CH_ZERO);
        if (pval > VAR_MAX) parse_error();
      end
      cnfp_pkg::MODE_COMMENT: begin
        if (eoi) begin
          pmode = cnfp_pkg::MODE_DONE;
          emit(cnfp_pkg::KIND_DONE, 24'd0, 1'b0);
        end else if (c == cnfp_pkg::CH_NEWLINE) begin
          pmode = cnfp_pkg::MODE_TOP;
        end
      end
      default: ;   // error and done swallow everything
    endcase
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    parse_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind=%0d var=%0d",
                                out_tuser, out_tdata[23:0]));
      end else begin
        w = pending_words.pop_front();
        if (out_tuser != w.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", out_tuser, w.kind));
        if (out_tdata[23:0] != w.variable)
          flag_mismatch($sformatf("variable %0d, want %0d", out_tdata[23:0], w.variable));
        if (out_tdata[24] != w.negated)
          flag_mismatch($sformatf("negated %0b, want %0b", out_tdata[24], w.negated));
        if (out_tdata[31:25] != 7'd0)
          flag_mismatch($sformatf("pad bits %h not zero", out_tdata[31:25]));
        if (out_tlast != w.last)
          flag_mismatch($sformatf("tlast %0b, want %0b", out_tlast, w.last));
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // ---------------------------------------------------------------- stimulus

  // one byte across the input handshake; the prediction is made on acceptance
  task automatic send_char(input logic [7:0] c, input logic eoi = 1'b0,
                           input bit typed = 1'b0,
                           input cnfp_pkg::kind_t tk = cnfp_pkg::KIND_LIT,
                           input logic [23:0] tv = 24'd0, input logic tn = 1'b0);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(c, eoi);
    if (typed) begin
      step_words.delete();
      emit(tk, tv, tn);
      step_words[0].last = 1'b1;
    end
    foreach (step_words[i]) pending_words.insert(pending_words.size(), step_words[i]);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic ws_run(input int min_len);
    int n;
    int k;
    n = $urandom_range(min_len, 3);
    repeat (n) begin
      k = $urandom_range(9, 14);
      send_char((k == 14) ? cnfp_pkg::CH_SPACE : 8'(k));
    end
  endtask

  function automatic logic [7:0] comment_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == cnfp_pkg::CH_NEWLINE) ? 8'h8A : b;
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (is_ws(b) || is_dig(b) || b == cnfp_pkg::CH_MINUS || b == cnfp_pkg::CH_PLUS);
    return b;
  endfunction

  // mostly small variables, some across the whole range, a few at the top
  function automatic longint unsigned rand_var();
    case ($urandom_range(0, 9))
      0: return VAR_MAX;
      1: return $urandom_range(1, int'(VAR_MAX));
      2: return $urandom_range(1, 9);
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  function automatic sign_t rand_sign();
    return sign_t'($urandom_range(0, 2));
  endfunction

  task automatic send_comment();
    int n;
    send_char(($urandom_range(0, 1) != 0) ? cnfp_pkg::CH_C : cnfp_pkg::CH_P);
    n = $urandom_range(0, 12);
    repeat (n) send_char(comment_byte());
    send_char(cnfp_pkg::CH_NEWLINE);
  endtask

  // optional sign, occasional leading zeros, then the decimal digits
  task automatic send_number(input sign_t sg, input longint unsigned v);
    string s;
    int lz;
    s = $sformatf("%0d", v);
    lz = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
    if (sg == SGN_MINUS) send_char(cnfp_pkg::CH_MINUS);
    else if (sg == SGN_PLUS) send_char(cnfp_pkg::CH_PLUS);
    repeat (lz) send_char(cnfp_pkg::CH_ZERO);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // a number after another one needs whitespace unless it opens with a sign
  task automatic send_separated(input sign_t sg, input longint unsigned v, input bit first);
    if (!first) begin
      if (sg == SGN_NONE || $urandom_range(0, 1) != 0) ws_run(1);
    end
    send_number(sg, v);
  endtask

  // well-formed clause, left at top level with whitespace or a comment after it
  task automatic send_clause();
    int nlit;
    nlit = $urandom_range(0, 5);
    for (int i = 0; i < nlit; i++) send_separated(rand_sign(), rand_var(), i == 0);
    send_separated(rand_sign(), 0, nlit == 0);
    if ($urandom_range(0, 3) == 0) send_comment();
    else ws_run(1);
  endtask

  // close the stream in one of the terminal ways, starting from top level
  task automatic send_ending();
    ending_t how;
    how = ending_t'($urandom_range(0, 10));
    case (how)
      END_AT_TOP: send_char(8'($urandom_range(0, 255)), 1'b1);
      END_IN_COMMENT: begin
        send_char(cnfp_pkg::CH_C);
        send_char(comment_byte());
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      END_AFTER_ZERO: begin
        send_number(SGN_NONE, rand_var());
        ws_run(1);
        send_number(SGN_NONE, 0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      END_IN_DIGITS: begin
        send_number(rand_sign(), rand_var());
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      END_IN_CLAUSE: begin
        send_number(rand_sign(), rand_var());
        ws_run(1);
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      BAD_IN_CLAUSE: begin
        send_number(rand_sign(), rand_var());
        ws_run(1);
        send_char(bad_char());
      end
      BAD_AFTER_DIGITS: begin
        send_number(rand_sign(), rand_var());
        send_char(bad_char());
      end
      SIGN_THEN_SPACE: begin
        send_char(cnfp_pkg::CH_MINUS);
        ws_run(1);
      end
      SIGN_THEN_END: begin
        send_char(cnfp_pkg::CH_PLUS);
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      SIGN_THEN_BAD: begin
        send_char(cnfp_pkg::CH_MINUS);
        send_char(bad_char());
      end
      default: send_number(rand_sign(), VAR_MAX + $urandom_range(1, 999999));
    endcase
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_char(dir_tab[i].data, dir_tab[i].eoi, dir_tab[i].typed,
                dir_tab[i].kind, dir_tab[i].variable, dir_tab[i].neg);

    // random clauses and comment lines, all well formed until the ending
    while (n_sent < RANDOM_BYTES) begin
      if (n_sent >= CALM_FROM && n_sent < CALM_TO) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = 34;
        out_idle_pct = 34;
      end
      if (!paused && n_sent >= PAUSE_AT) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) send_comment();
      else send_clause();
    end
    send_ending();

    // parser is now stuck in done or error: these must cause nothing
    repeat (8) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
